@@ hw/rtl/mis_pkg.sv @@
// Shared types and constants for the merge-insertion sorter.
// Holds the input and result word layouts and the cell command struct.
// No dependencies.
package mis_pkg;

    localparam int MIS_VALUE_W  = 31;
    localparam int MIS_CAPACITY = 32;

    typedef logic [MIS_VALUE_W-1:0] value_t;

    typedef struct packed {
        value_t value;
        logic   is_last;
    } in_word_t;

    typedef struct packed {
        value_t sorted_value;
        logic   last_out;
        logic   overflowed;
    } out_word_t;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } cell_cmd_t;

endpackage

@@ hw/rtl/merge_insertion_sorter_core.sv @@
// Top level of the merge-insertion sorter: a chain of sorting cells and drain control.
// Instantiates mis_cell; depends on mis_pkg.
//
// Channel  Direction  Ports                      Word
// s_       in         s_valid s_ready s_data     in_word_t  (value, is_last)
// m_       out        m_valid m_ready m_data     out_word_t (sorted_value, last_out, overflowed)
//
// Each input word is placed into the chain by a broadcast compare unless the chain is full.
// After a word with is_last, the chain drains one value per cycle into the output
// register whenever m_ready does not stall it.
// s_ready is low while the chain drains; m_ready low stalls the drain.
// Reset empties the chain and clears the overflow flag.
module merge_insertion_sorter_core
    import mis_pkg::*;
#(
    parameter int CAPACITY = MIS_CAPACITY
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    value_t              value_w [CAPACITY];
    logic [CAPACITY-1:0] occ_w;
    logic [CAPACITY-1:0] gt_w;
    cell_cmd_t           cmd;

    logic      drain_reg;
    logic      drain_next;
    logic      ovf_reg;
    logic      ovf_next;
    logic      m_valid_reg;
    logic      m_valid_next;
    out_word_t m_data_reg;
    out_word_t m_data_next;

    logic accept_in;
    logic full;
    logic load;
    logic final_word;

    assign s_ready    = !drain_reg;
    assign accept_in  = s_valid && s_ready;
    assign full       = occ_w[CAPACITY-1];
    assign load       = drain_reg && (!m_valid_reg || m_ready);
    assign final_word = !occ_w[1];

    assign cmd.insert    = accept_in && !full;
    assign cmd.shift_out = load;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        value_t left_value;
        logic   left_occ;
        logic   left_gt;
        value_t right_value;
        logic   right_occ;

        if (i == 0) begin : g_first
            assign left_value = '0;
            assign left_occ   = 1'b1;
            assign left_gt    = 1'b0;
        end else begin : g_mid_left
            assign left_value = value_w[i-1];
            assign left_occ   = occ_w[i-1];
            assign left_gt    = gt_w[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value = '0;
            assign right_occ   = 1'b0;
        end else begin : g_mid_right
            assign right_value = value_w[i+1];
            assign right_occ   = occ_w[i+1];
        end

        mis_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .ins_value   (s_data.value),
            .left_value  (left_value),
            .left_occ    (left_occ),
            .left_gt     (left_gt),
            .right_value (right_value),
            .right_occ   (right_occ),
            .value       (value_w[i]),
            .occ         (occ_w[i]),
            .gt          (gt_w[i])
        );
    end

    always_comb begin
        drain_next   = drain_reg;
        ovf_next     = ovf_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (accept_in) begin
            if (full) begin
                ovf_next = 1'b1;
            end
            if (s_data.is_last) begin
                drain_next = 1'b1;
            end
        end
        if (load) begin
            m_valid_next             = 1'b1;
            m_data_next.sorted_value = value_w[0];
            m_data_next.last_out     = final_word;
            m_data_next.overflowed   = ovf_reg;
            if (final_word) begin
                drain_next = 1'b0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            drain_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            drain_reg   <= drain_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_occ_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        ((occ_w + 1'b1) & occ_w) == '0)
        else $error("occupied cells are not a contiguous run from cell zero");

    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_reg |-> occ_w[0])
        else $error("draining with an empty chain");

    a_last_starts_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept_in && s_data.is_last) |=> drain_reg)
        else $error("final word of a run did not start the drain");
`endif

endmodule

@@ hw/rtl/mis_cell.sv @@
// One cell of the sorting chain: a stored value and an occupied bit.
// Inserts by comparing against the broadcast value, drains toward cell zero.
// Depends on mis_pkg.
module mis_cell
    import mis_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_cmd_t cmd,
    input  value_t    ins_value,
    input  value_t    left_value,
    input  logic      left_occ,
    input  logic      left_gt,
    input  value_t    right_value,
    input  logic      right_occ,
    output value_t    value,
    output logic      occ,
    output logic      gt
);

    value_t value_reg;
    value_t value_next;
    logic   occ_reg;
    logic   occ_next;

    assign gt    = occ_reg && (value_reg > ins_value);
    assign value = value_reg;
    assign occ   = occ_reg;

    always_comb begin
        value_next = value_reg;
        occ_next   = occ_reg;
        if (cmd.shift_out) begin
            value_next = right_value;
            occ_next   = right_occ;
        end else if (cmd.insert) begin
            if (gt) begin
                value_next = left_gt ? left_value : ins_value;
            end else if (!occ_reg && left_gt) begin
                value_next = left_value;
                occ_next   = 1'b1;
            end else if (!occ_reg && left_occ) begin
                value_next = ins_value;
                occ_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

endmodule
